[design/serial_command_line_assembler_unit_defines.svh]
// Assertion macros shared by the serial command line assembler RTL.
`ifndef SERIAL_COMMAND_LINE_ASSEMBLER_UNIT_DEFINES_SVH
`define SERIAL_COMMAND_LINE_ASSEMBLER_UNIT_DEFINES_SVH

// Condition that must hold at every clock edge out of reset.
`define SCLA_ASSERT_HOLD(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error(msg);

// Condition that must follow in the same cycle whenever the antecedent holds.
`define SCLA_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

[design/scla_pkg.sv]
// Shared types and constants of the serial command line assembler.
package scla_pkg;

	// Fixed field widths
	localparam int BYTE_W = 8;
	localparam int FILL_W = 6;
	localparam int KIND_W = 3;

	// Store depth limit and default line buffer size
	localparam int STORE_DEPTH    = 63;
	localparam int LINE_BYTES_DEF = 64;

	// Terminal byte codes
	localparam logic [BYTE_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [BYTE_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [BYTE_W-1:0] CHAR_VT    = 8'h0B;
	localparam logic [BYTE_W-1:0] CHAR_FF    = 8'h0C;
	localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_TILDE = 8'h7E;
	localparam logic [BYTE_W-1:0] CHAR_DEL   = 8'h7F;

	// Result kinds
	typedef enum logic [KIND_W-1:0] {
		KIND_ECHO      = 3'd0,
		KIND_ERASE     = 3'd1,
		KIND_LINE_CHAR = 3'd2,
		KIND_EMPTY     = 3'd3,
		KIND_ERROR     = 3'd4
	} kind_t;

	// Line error codes
	localparam logic ERR_BAD_CHAR = 1'b0;
	localparam logic ERR_TOO_LONG = 1'b1;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_EMIT
	} state_t;

	// Decode of one received byte
	typedef struct packed {
		logic              is_cr;
		logic              is_lf;
		logic              is_erase;
		logic              is_store;
		logic [BYTE_W-1:0] echo_char;
	} byte_class_t;

endpackage

[design/scla_class.sv]
// Byte decoder: sorts a received byte into line end, erase, storable or invalid.
module scla_class (
	input  logic [scla_pkg::BYTE_W-1:0] rx_byte,
	output scla_pkg::byte_class_t       cls
);

	always_comb begin
		cls.is_cr    = (rx_byte == scla_pkg::CHAR_CR);
		cls.is_lf    = (rx_byte == scla_pkg::CHAR_LF);
		cls.is_erase = (rx_byte == scla_pkg::CHAR_BS) || (rx_byte == scla_pkg::CHAR_DEL);
		// printable range plus TAB, VT and FF
		cls.is_store = ((rx_byte >= scla_pkg::CHAR_SPACE) && (rx_byte <= scla_pkg::CHAR_TILDE))
			|| (rx_byte == scla_pkg::CHAR_TAB) || (rx_byte == scla_pkg::CHAR_VT)
			|| (rx_byte == scla_pkg::CHAR_FF);
		// control characters echo as a space
		cls.echo_char = (rx_byte >= scla_pkg::CHAR_SPACE) ? rx_byte : scla_pkg::CHAR_SPACE;
	end

endmodule

[design/scla_store.sv]
// Line store: one write port, one read port with registered read data.
module scla_store #(
	parameter int DEPTH = scla_pkg::STORE_DEPTH,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [scla_pkg::BYTE_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [scla_pkg::BYTE_W-1:0] rd_data
);

	logic [scla_pkg::BYTE_W-1:0] mem_q [DEPTH];
	logic [scla_pkg::BYTE_W-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[design/scla_seq.sv]
// Sequencer: byte handling, line state, store readout and result register.
`include "serial_command_line_assembler_unit_defines.svh"

module scla_seq #(
	parameter int LINE_CAP = scla_pkg::STORE_DEPTH,
	parameter int AW       = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// received byte transaction
	input  logic                        rx_valid,
	output logic                        rx_ready,
	input  logic [scla_pkg::BYTE_W-1:0] rx_byte,
	// decoder
	output logic [scla_pkg::BYTE_W-1:0] byte_out,
	input  scla_pkg::byte_class_t       cls,
	// line store
	output logic                        wr_en,
	output logic [AW-1:0]               wr_addr,
	output logic [scla_pkg::BYTE_W-1:0] wr_data,
	output logic                        rd_en,
	output logic [AW-1:0]               rd_addr,
	input  logic [scla_pkg::BYTE_W-1:0] rd_data,
	// result transaction
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [scla_pkg::KIND_W-1:0] kind,
	output logic [scla_pkg::BYTE_W-1:0] char_value,
	output logic                        error_code,
	output logic [scla_pkg::FILL_W-1:0] line_length,
	output logic                        last
);

	localparam logic [scla_pkg::FILL_W-1:0] CAP = scla_pkg::FILL_W'(LINE_CAP);
	localparam logic [scla_pkg::FILL_W-1:0] ONE = scla_pkg::FILL_W'(1);

	scla_pkg::state_t            state_q, state_d;
	logic [scla_pkg::BYTE_W-1:0] byte_q;
	logic [scla_pkg::FILL_W-1:0] fill_q, fill_d;
	logic                        discard_q, discard_d;
	logic                        bad_q, bad_d;
	logic                        swallow_q, swallow_d;
	logic [scla_pkg::FILL_W-1:0] len_q, len_d;
	logic [scla_pkg::FILL_W-1:0] idx_q, idx_d;
	logic [scla_pkg::FILL_W-1:0] idx_next;

	// result register
	logic                        res_valid_q;
	scla_pkg::kind_t             res_kind_q;
	logic [scla_pkg::BYTE_W-1:0] res_char_q;
	logic                        res_err_q;
	logic [scla_pkg::FILL_W-1:0] res_len_q;
	logic                        res_last_q;

	logic                        slot_free;
	logic                        emit;
	scla_pkg::kind_t             emit_kind;
	logic [scla_pkg::BYTE_W-1:0] emit_char;
	logic                        emit_err;
	logic [scla_pkg::FILL_W-1:0] emit_len;
	logic                        emit_last;

	// held result classes, for the checks
	logic                        res_single;
	logic                        res_line;

	assign slot_free = !res_valid_q || res_ready;
	assign idx_next  = idx_q + ONE;
	assign rx_ready  = (state_q == scla_pkg::ST_IDLE);
	assign byte_out  = byte_q;
	assign wr_addr   = fill_q[AW-1:0];
	assign wr_data   = byte_q;
	assign rd_addr   = idx_q[AW-1:0];

	// Next state, line state updates and result loading
	always_comb begin
		state_d   = state_q;
		fill_d    = fill_q;
		discard_d = discard_q;
		bad_d     = bad_q;
		swallow_d = swallow_q;
		len_d     = len_q;
		idx_d     = idx_q;
		emit      = 1'b0;
		emit_kind = scla_pkg::KIND_ECHO;
		emit_char = '0;
		emit_err  = 1'b0;
		emit_len  = '0;
		emit_last = 1'b1;
		wr_en     = 1'b0;
		rd_en     = 1'b0;
		case (state_q)
			scla_pkg::ST_IDLE: begin
				if (rx_valid) begin
					state_d = scla_pkg::ST_EXEC;
				end
			end
			scla_pkg::ST_EXEC: begin
				if (slot_free) begin
					state_d   = scla_pkg::ST_IDLE;
					swallow_d = 1'b0;
					if (swallow_q && cls.is_lf) begin
						// LF right after CR: dropped
					end else if (cls.is_cr || cls.is_lf) begin
						swallow_d = cls.is_cr;
						fill_d    = '0;
						discard_d = 1'b0;
						bad_d     = 1'b0;
						if (discard_q) begin
							emit      = 1'b1;
							emit_kind = scla_pkg::KIND_ERROR;
							emit_err  = bad_q ? scla_pkg::ERR_BAD_CHAR : scla_pkg::ERR_TOO_LONG;
						end else if (fill_q != '0) begin
							len_d   = fill_q;
							idx_d   = '0;
							state_d = scla_pkg::ST_READ;
						end else begin
							emit      = 1'b1;
							emit_kind = scla_pkg::KIND_EMPTY;
						end
					end else if (discard_q) begin
						// rest of the line is ignored
					end else if (cls.is_erase) begin
						if (fill_q != '0) begin
							fill_d    = fill_q - ONE;
							emit      = 1'b1;
							emit_kind = scla_pkg::KIND_ERASE;
						end
					end else if (!cls.is_store) begin
						discard_d = 1'b1;
						bad_d     = 1'b1;
					end else if (fill_q < CAP) begin
						wr_en     = 1'b1;
						fill_d    = fill_q + ONE;
						emit      = 1'b1;
						emit_kind = scla_pkg::KIND_ECHO;
						emit_char = cls.echo_char;
					end else begin
						// overflow
						fill_d    = '0;
						discard_d = 1'b1;
					end
				end
			end
			scla_pkg::ST_READ: begin
				rd_en   = 1'b1;
				state_d = scla_pkg::ST_EMIT;
			end
			scla_pkg::ST_EMIT: begin
				if (slot_free) begin
					emit      = 1'b1;
					emit_kind = scla_pkg::KIND_LINE_CHAR;
					emit_char = rd_data;
					emit_len  = len_q;
					emit_last = (idx_next == len_q);
					if (idx_next == len_q) begin
						state_d = scla_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_next;
						state_d = scla_pkg::ST_READ;
					end
				end
			end
			default: begin
				state_d = scla_pkg::ST_IDLE;
			end
		endcase
	end

	// State register and line state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= scla_pkg::ST_IDLE;
			fill_q    <= '0;
			discard_q <= 1'b0;
			bad_q     <= 1'b0;
			swallow_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			fill_q    <= fill_d;
			discard_q <= discard_d;
			bad_q     <= bad_d;
			swallow_q <= swallow_d;
		end
	end

	// Captured byte and readout counters
	always_ff @(posedge clk) begin
		if (rx_valid && rx_ready) begin
			byte_q <= rx_byte;
		end
		len_q <= len_d;
		idx_q <= idx_d;
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (emit) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			res_kind_q <= emit_kind;
			res_char_q <= emit_char;
			res_err_q  <= emit_err;
			res_len_q  <= emit_len;
			res_last_q <= emit_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign kind        = res_kind_q;
	assign char_value  = res_char_q;
	assign error_code  = res_err_q;
	assign line_length = res_len_q;
	assign last        = res_last_q;

	assign res_single = res_valid_q && (res_kind_q != scla_pkg::KIND_LINE_CHAR);
	assign res_line   = res_valid_q && (res_kind_q == scla_pkg::KIND_LINE_CHAR);

	// Checks
	`SCLA_ASSERT_HOLD(a_fill_in_range, fill_q <= CAP, "fill count beyond line capacity")
	`SCLA_ASSERT_IMPL(a_bad_needs_discard, bad_q, discard_q, "bad char flag without discard")
	`SCLA_ASSERT_IMPL(a_single_is_last, res_single, res_last_q, "single result not last")
	`SCLA_ASSERT_IMPL(a_line_len_ok, res_line, (res_len_q != '0) && (res_len_q <= CAP), "bad length")

endmodule

[design/serial_command_line_assembler_unit.sv]
// Top level of the serial command line assembler.
//
//   channel | direction | handshake            | payload
//   rx      | in        | rx_valid / rx_ready  | rx_byte
//   res     | out       | res_valid / res_ready| kind, char_value, error_code,
//           |           |                      | line_length, last
//
// A byte is first captured, then acted on by the sequencer in its EXEC state
// once the result register is free. A line end with n stored characters then
// reads them out one by one through READ and EMIT; the line store has a single
// registered read port. The result register lets a new byte be captured while
// a result waits. Reset clears the line state; the store needs no clearing pass.
module serial_command_line_assembler_unit #(
	parameter int LINE_BYTES = scla_pkg::LINE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rx_valid,
	output logic                        rx_ready,
	input  logic [scla_pkg::BYTE_W-1:0] rx_byte,
	output logic                        res_valid,
	input  logic                        res_ready,
	output logic [scla_pkg::KIND_W-1:0] kind,
	output logic [scla_pkg::BYTE_W-1:0] char_value,
	output logic                        error_code,
	output logic [scla_pkg::FILL_W-1:0] line_length,
	output logic                        last
);

	localparam int LINE_CAP = ((LINE_BYTES - 1) > scla_pkg::STORE_DEPTH) ?
		scla_pkg::STORE_DEPTH : (LINE_BYTES - 1);
	localparam int AW = (LINE_CAP > 1) ? $clog2(LINE_CAP) : 1;

	logic [scla_pkg::BYTE_W-1:0] cur_byte;
	scla_pkg::byte_class_t       cls;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [scla_pkg::BYTE_W-1:0] wr_data;
	logic                        rd_en;
	logic [AW-1:0]               rd_addr;
	logic [scla_pkg::BYTE_W-1:0] rd_data;

	// Byte decode
	scla_class u_class (
		.rx_byte (cur_byte),
		.cls     (cls)
	);

	// Line store
	scla_store #(
		.DEPTH (LINE_CAP),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Sequencer
	scla_seq #(
		.LINE_CAP (LINE_CAP),
		.AW       (AW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx_valid    (rx_valid),
		.rx_ready    (rx_ready),
		.rx_byte     (rx_byte),
		.byte_out    (cur_byte),
		.cls         (cls),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.kind        (kind),
		.char_value  (char_value),
		.error_code  (error_code),
		.line_length (line_length),
		.last        (last)
	);

endmodule

[bench/serial_command_line_assembler_unit_test.sv]
// Self-checking testbench for the serial command line assembler: directed rows, then random lines.
module serial_command_line_assembler_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BW           = scla_pkg::BYTE_W;
	localparam int FW           = scla_pkg::FILL_W;
	localparam int LINE_BYTES   = scla_pkg::LINE_BYTES_DEF;
	localparam int LINE_CAP     = (LINE_BYTES - 1 > scla_pkg::STORE_DEPTH) ?
		scla_pkg::STORE_DEPTH : LINE_BYTES - 1;
	localparam int RANDOM_ITEMS = 355;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int TAIL_CYCLES  = 20;
	localparam int N_DIRECTED   = 25;

	// One result transaction as the block presents it
	typedef struct packed {
		scla_pkg::kind_t kind;
		logic [BW-1:0]   char_value;
		logic            error_code;
		logic [FW-1:0]   line_length;
		logic            last;
	} line_result_t;

	// One directed row: the byte, and optionally a hand-typed outcome
	typedef struct packed {
		logic [BW-1:0] rx_byte;
		logic          by_hand;
		logic          gives_result;
		line_result_t  hand_result;
	} stim_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          rx_valid;
	logic                          rx_ready;
	logic [BW-1:0]                 rx_byte;
	logic                          res_valid;
	logic                          res_ready;
	logic [scla_pkg::KIND_W-1:0]   kind;
	logic [BW-1:0]                 char_value;
	logic                          error_code;
	logic [FW-1:0]                 line_length;
	logic                          last;

	// Line editor state mirrored by the bench
	logic [BW-1:0] shadow_store [scla_pkg::STORE_DEPTH];
	int            shadow_fill;
	bit            shadow_discard;
	bit            shadow_bad_char;
	bit            shadow_swallow_lf;

	line_result_t line_events [$];
	line_result_t awaited_results [$];
	stim_row_t    directed_rows [N_DIRECTED];
	int           mismatches;
	int           cycle_count;

	serial_command_line_assembler_unit #(
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.kind       (kind),
		.char_value (char_value),
		.error_code (error_code),
		.line_length(line_length),
		.last       (last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic line_result_t make_result(scla_pkg::kind_t k, logic [BW-1:0] ch,
			logic err, logic [FW-1:0] len, logic fin);
		line_result_t r;
		r.kind        = k;
		r.char_value  = ch;
		r.error_code  = err;
		r.line_length = len;
		r.last        = fin;
		return r;
	endfunction

	function automatic stim_row_t auto_row(logic [BW-1:0] b);
		return '{rx_byte: b, by_hand: 1'b0, gives_result: 1'b0, hand_result: '0};
	endfunction

	function automatic stim_row_t hand_row(logic [BW-1:0] b, line_result_t r);
		return '{rx_byte: b, by_hand: 1'b1, gives_result: 1'b1, hand_result: r};
	endfunction

	function automatic stim_row_t quiet_row(logic [BW-1:0] b);
		return '{rx_byte: b, by_hand: 1'b1, gives_result: 1'b0, hand_result: '0};
	endfunction

	// Printable range plus TAB, VT and FF go into the line
	function automatic bit is_line_char(logic [BW-1:0] b);
		return (b >= scla_pkg::CHAR_SPACE && b <= scla_pkg::CHAR_TILDE) ||
			b == scla_pkg::CHAR_TAB || b == scla_pkg::CHAR_VT || b == scla_pkg::CHAR_FF;
	endfunction

	function automatic logic [BW-1:0] invalid_byte();
		logic [BW-1:0] b;
		do
			b = BW'($urandom_range(0, 255));
		while (is_line_char(b) || b == scla_pkg::CHAR_BS || b == scla_pkg::CHAR_DEL ||
			b == scla_pkg::CHAR_CR || b == scla_pkg::CHAR_LF);
		return b;
	endfunction

	// Line editor prediction: fills line_events with what one byte causes
	task automatic edit_line(input logic [BW-1:0] b);
		line_events.delete();
		// LF right after CR is dropped; anything else just clears the flag
		if (shadow_swallow_lf) begin
			shadow_swallow_lf = 1'b0;
			if (b == scla_pkg::CHAR_LF)
				return;
		end
		// line end: error, stored run, or empty marker
		if (b == scla_pkg::CHAR_CR || b == scla_pkg::CHAR_LF) begin
			shadow_swallow_lf = (b == scla_pkg::CHAR_CR);
			if (shadow_discard)
				line_events.push_back(make_result(scla_pkg::KIND_ERROR, '0,
					shadow_bad_char ? scla_pkg::ERR_BAD_CHAR : scla_pkg::ERR_TOO_LONG,
					'0, 1'b1));
			else if (shadow_fill > 0)
				for (int i = 0; i < shadow_fill; i++)
					line_events.push_back(make_result(scla_pkg::KIND_LINE_CHAR,
						shadow_store[i], 1'b0, FW'(shadow_fill), i == shadow_fill - 1));
			else
				line_events.push_back(make_result(scla_pkg::KIND_EMPTY, '0, 1'b0, '0, 1'b1));
			shadow_fill     = 0;
			shadow_discard  = 1'b0;
			shadow_bad_char = 1'b0;
			return;
		end
		if (shadow_discard)
			return;
		// erase
		if (b == scla_pkg::CHAR_BS || b == scla_pkg::CHAR_DEL) begin
			if (shadow_fill > 0) begin
				shadow_fill--;
				line_events.push_back(make_result(scla_pkg::KIND_ERASE, '0, 1'b0, '0, 1'b1));
			end
			return;
		end
		if (!is_line_char(b)) begin
			shadow_discard  = 1'b1;
			shadow_bad_char = 1'b1;
			return;
		end
		// store and echo, or overflow into discard
		if (shadow_fill < LINE_CAP) begin
			shadow_store[shadow_fill] = b;
			shadow_fill++;
			line_events.push_back(make_result(scla_pkg::KIND_ECHO,
				(b >= scla_pkg::CHAR_SPACE) ? b : scla_pkg::CHAR_SPACE, 1'b0, '0, 1'b1));
		end else begin
			shadow_fill    = 0;
			shadow_discard = 1'b1;
		end
	endtask

	// Drive one byte transaction, then record what it should produce
	task automatic send_byte(input stim_row_t row, input bit calm, inout int count);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 10);
		@(negedge clk);
		if (gap > 0) begin
			rx_valid <= 1'b0;
			rx_byte  <= BW'($urandom_range(0, 255));
			repeat (gap) @(negedge clk);
		end
		rx_valid <= 1'b1;
		rx_byte  <= row.rx_byte;
		do @(posedge clk); while (!(rx_valid && rx_ready));
		edit_line(row.rx_byte);
		count++;
		if (row.by_hand) begin
			if (row.gives_result)
				awaited_results.push_back(row.hand_result);
		end else begin
			foreach (line_events[i])
				awaited_results.push_back(line_events[i]);
		end
	endtask

	// One random line: mostly well-formed, some broken, some plain noise
	task automatic send_line(inout int count);
		int pick;
		int len;
		int bad_at;
		bit calm;
		logic [BW-1:0] b;
		calm = ($urandom_range(0, 3) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			repeat ($urandom_range(1, 6))
				send_byte(auto_row(BW'($urandom_range(0, 255))), calm, count);
			return;
		end
		case ($urandom_range(0, 14))
			0: begin
				len = $urandom_range(58, LINE_CAP);
			end
			1: begin
				len = $urandom_range(LINE_CAP + 1, LINE_CAP + 5);
			end
			default: begin
				len = $urandom_range(0, 12);
			end
		endcase
		bad_at = (pick < 28) ? $urandom_range(0, len) : -1;
		for (int i = 0; i <= len; i++) begin
			if (i == bad_at)
				send_byte(auto_row(invalid_byte()), calm, count);
			if (i == len)
				break;
			// short lines get the odd erase mixed in
			if (len < 20 && $urandom_range(0, 7) == 0)
				send_byte(auto_row($urandom_range(0, 1) ? scla_pkg::CHAR_BS :
					scla_pkg::CHAR_DEL), calm, count);
			case ($urandom_range(0, 15))
				0: b = scla_pkg::CHAR_TAB;
				1: b = scla_pkg::CHAR_VT;
				2: b = scla_pkg::CHAR_FF;
				default: b = BW'($urandom_range(32, 126));
			endcase
			send_byte(auto_row(b), calm, count);
		end
		// terminator: CR, LF or CR LF
		case ($urandom_range(0, 2))
			0: begin
				send_byte(auto_row(scla_pkg::CHAR_CR), calm, count);
			end
			1: begin
				send_byte(auto_row(scla_pkg::CHAR_LF), calm, count);
			end
			default: begin
				send_byte(auto_row(scla_pkg::CHAR_CR), calm, count);
				send_byte(auto_row(scla_pkg::CHAR_LF), calm, count);
			end
		endcase
	endtask

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Result monitor
	always @(posedge clk) begin
		line_result_t want;
		if (arst_n && res_valid && res_ready) begin
			if (awaited_results.size() == 0) begin
				$display("%0t: result with nothing expected, got kind %0d char %0h",
					$time, kind, char_value);
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				check_field("kind", want.kind, kind);
				check_field("char_value", want.char_value, char_value);
				check_field("error_code", want.error_code, error_code);
				check_field("line_length", want.line_length, line_length);
				check_field("last", want.last, last);
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[serial_command_line_assembler_unit] ERROR");
			$finish;
		end
	end

	// Result side: random stalls, with calm stretches now and then
	initial begin
		int stall;
		bit calm;
		res_ready = 1'b0;
		calm      = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 31) == 0)
				calm = !calm;
			stall = calm ? 0 : $urandom_range(0, 10);
			@(negedge clk);
			if (stall > 0) begin
				res_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			res_ready <= 1'b1;
			do @(posedge clk); while (!(res_valid && res_ready));
		end
	end

	// Main sequence
	initial begin
		int directed_count;
		int random_count;
		rx_valid          = 1'b0;
		rx_byte           = '0;
		arst_n            = 1'b0;
		mismatches        = 0;
		cycle_count       = 0;
		shadow_fill       = 0;
		shadow_discard    = 1'b0;
		shadow_bad_char   = 1'b0;
		shadow_swallow_lf = 1'b0;
		directed_count    = 0;
		random_count      = 0;

		directed_rows = '{
			hand_row(scla_pkg::CHAR_CR,
				make_result(scla_pkg::KIND_EMPTY, '0, 1'b0, '0, 1'b1)),
			quiet_row(scla_pkg::CHAR_LF),                        // LF after CR dropped
			hand_row(scla_pkg::CHAR_LF,
				make_result(scla_pkg::KIND_EMPTY, '0, 1'b0, '0, 1'b1)),
			quiet_row(scla_pkg::CHAR_BS),                        // erase on empty line
			hand_row(scla_pkg::CHAR_SPACE,
				make_result(scla_pkg::KIND_ECHO, scla_pkg::CHAR_SPACE, 1'b0, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_TILDE,
				make_result(scla_pkg::KIND_ECHO, scla_pkg::CHAR_TILDE, 1'b0, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_TAB,
				make_result(scla_pkg::KIND_ECHO, scla_pkg::CHAR_SPACE, 1'b0, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_VT,
				make_result(scla_pkg::KIND_ECHO, scla_pkg::CHAR_SPACE, 1'b0, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_FF,
				make_result(scla_pkg::KIND_ECHO, scla_pkg::CHAR_SPACE, 1'b0, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_DEL,
				make_result(scla_pkg::KIND_ERASE, '0, 1'b0, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_BS,
				make_result(scla_pkg::KIND_ERASE, '0, 1'b0, '0, 1'b1)),
			auto_row(8'h41),
			auto_row(scla_pkg::CHAR_CR),                         // stored run, raw TAB kept
			auto_row(8'h78),                                     // non-LF after CR
			quiet_row(8'h00),                                    // invalid byte
			quiet_row(8'h41),                                    // ignored while discarding
			quiet_row(scla_pkg::CHAR_BS),
			hand_row(scla_pkg::CHAR_LF,
				make_result(scla_pkg::KIND_ERROR, '0, scla_pkg::ERR_BAD_CHAR, '0, 1'b1)),
			quiet_row(8'hFF),
			hand_row(scla_pkg::CHAR_CR,
				make_result(scla_pkg::KIND_ERROR, '0, scla_pkg::ERR_BAD_CHAR, '0, 1'b1)),
			quiet_row(8'h80),
			hand_row(scla_pkg::CHAR_LF,
				make_result(scla_pkg::KIND_ERROR, '0, scla_pkg::ERR_BAD_CHAR, '0, 1'b1)),
			quiet_row(8'h1F),
			hand_row(scla_pkg::CHAR_CR,
				make_result(scla_pkg::KIND_ERROR, '0, scla_pkg::ERR_BAD_CHAR, '0, 1'b1)),
			hand_row(scla_pkg::CHAR_CR,
				make_result(scla_pkg::KIND_EMPTY, '0, 1'b0, '0, 1'b1))
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_byte(directed_rows[i], $urandom_range(0, 1), directed_count);

		while (random_count < RANDOM_ITEMS)
			send_line(random_count);

		@(negedge clk);
		rx_valid <= 1'b0;

		// drain, then give the block time to show any stray result
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("[serial_command_line_assembler_unit] OK");
		else
			$display("[serial_command_line_assembler_unit] ERROR");
		$finish;
	end

endmodule
